@@ hw/rtl/wnm_pkg.sv @@
// Types and constants shared by the wildcard name matcher and its cells.
package wnm_pkg;

   localparam int unsigned OPCODE_BITS = 2;
   localparam int unsigned INDEX_BITS  = 5;
   localparam int unsigned VALUE_BITS  = 16;
   localparam int unsigned LEN_BITS    = 6;

   localparam logic [OPCODE_BITS-1:0] OP_LOAD_MASK = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_NAME_CHAR = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_END_NAME  = 2'd2;

   localparam int unsigned STAR_CODE     = 42;
   localparam int unsigned QUESTION_CODE = 63;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [INDEX_BITS-1:0]  mask_index;
      logic [VALUE_BITS-1:0]  char_value;
   } req_item_type;

   typedef struct packed {
      logic full_match;
      logic prefix_may_match;
   } rsp_item_type;

   // Broadcast controls from the top level to every cell.
   typedef struct packed {
      logic load;       // mask load item accepted
      logic name_step;  // name character item accepted
      logic tok_step;   // name character item accepted, prefix still open
      logic rearm;      // end of name item accepted
   } cell_ctrl_type;

   // What one cell reports to the top level and to its right neighbor.
   typedef struct packed {
      logic act;        // position active (before star closure)
      logic star_prop;  // star inside the mask: activity spreads to the next position
      logic fwd;        // active position consumes the character, next position lights
      logic tok_pass;   // prefix walker moves to the next position
      logic tok_star;   // prefix walker met a star
      logic tok_miss;   // prefix walker met a mismatch or ran past the mask
   } cell_status_type;

endpackage

@@ hw/rtl/wnm_cell.sv @@
// One mask position: stored mask character, active bit and prefix walker token.
module wnm_cell import wnm_pkg::*; #(
   parameter int unsigned CHAR_BITS = 16,
   parameter int unsigned LEN_W     = 6,
   parameter int unsigned POSITION  = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [INDEX_BITS-1:0] load_index,
   input  logic [CHAR_BITS-1:0]  char_code,
   input  logic [LEN_W-1:0]      mask_len,
   input  logic                  closed,     // this position after star closure
   input  logic                  prev_fwd,
   input  logic                  prev_tok_pass,
   output cell_status_type       status
);

   localparam logic START_BIT = (POSITION == 0) ? 1'b1 : 1'b0;
   localparam logic INDEXABLE = (POSITION < (1 << INDEX_BITS)) ? 1'b1 : 1'b0;

   logic [CHAR_BITS-1:0] mask_char_ff, mask_char_in;
   logic                 act_ff, act_in;
   logic                 tok_ff, tok_in;
   logic                 in_range;
   logic                 is_star;
   logic                 char_hit;
   logic                 load_here;

   assign in_range  = LEN_W'(POSITION) < mask_len;
   assign is_star   = mask_char_ff == CHAR_BITS'(STAR_CODE);
   assign char_hit  = (mask_char_ff == CHAR_BITS'(QUESTION_CODE)) || (mask_char_ff == char_code);
   assign load_here = ctrl.load && INDEXABLE && (load_index == INDEX_BITS'(POSITION));

   assign status.act       = act_ff;
   assign status.star_prop = is_star && in_range;
   assign status.fwd       = closed && in_range && !is_star && char_hit;
   assign status.tok_pass  = tok_ff && in_range && !is_star && char_hit;
   assign status.tok_star  = tok_ff && in_range && is_star;
   assign status.tok_miss  = tok_ff && (!in_range || (!is_star && !char_hit));

   always_comb begin
      mask_char_in = load_here ? char_code : mask_char_ff;

      priority if (ctrl.name_step) begin
         // a star keeps its own position lit; otherwise activity arrives from the left
         act_in = (closed && in_range && is_star) || prev_fwd;
      end else if (ctrl.rearm) begin
         act_in = START_BIT;
      end else begin
         act_in = act_ff;
      end

      priority if (ctrl.tok_step) begin
         tok_in = prev_tok_pass;
      end else if (ctrl.rearm) begin
         tok_in = START_BIT;
      end else begin
         tok_in = tok_ff;
      end
   end

   always_ff @(posedge clock) begin
      mask_char_ff <= mask_char_in;
      if (reset) begin
         act_ff <= START_BIT;
         tok_ff <= START_BIT;
      end else begin
         act_ff <= act_in;
         tok_ff <= tok_in;
      end
   end

endmodule

@@ hw/rtl/wnm_skid.sv @@
// Two-entry result buffer: output register plus skid register.
module wnm_skid import wnm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      // no push can arrive while the skid register is occupied
      priority if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_item_in  = push_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = push_item;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule

@@ hw/rtl/wildcard_name_matcher.sv @@
// Wildcard name matcher: streams a name one character per item against a stored mask
// where star matches any run and question matches one character. The block takes one
// item every cycle while req_stall is low: each item updates a row of MASK_DEPTH cells
// once, with the star closure done by a single MASK_DEPTH+2 bit carry chain across the row.
// The result of an end-of-name item is presented the cycle after it is accepted when the
// output register is free, later when it has to wait in the skid register; the two-entry
// output buffer lets input continue while one result waits, and req_stall rises only when
// both entries are taken. Mask loads and length writes apply from the next item on; there
// is no clearing pass after reset.
module wildcard_name_matcher import wnm_pkg::*; #(
   parameter int unsigned MASK_DEPTH = 32,
   parameter int unsigned CHAR_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_item_type        req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_item_type        rsp_item,
   input  logic                csr_wr_en,
   input  logic [LEN_BITS-1:0] csr_wr_data
);

   localparam int unsigned LEN_W = $clog2(MASK_DEPTH + 1);

   logic                 req_accept;
   logic [CHAR_BITS-1:0] char_code;
   cell_ctrl_type        ctrl;
   cell_status_type      status [MASK_DEPTH];

   logic [LEN_W-1:0] mask_len_ff, mask_len_in;
   logic             act_end_ff, act_end_in;
   logic             tok_end_ff, tok_end_in;
   logic             decided_ff, decided_in;
   logic             verdict_ff, verdict_in;

   logic [MASK_DEPTH:0]   gen_vec;
   logic [MASK_DEPTH:0]   prop_vec;
   logic [MASK_DEPTH+1:0] add_a;
   logic [MASK_DEPTH+1:0] add_b;
   logic [MASK_DEPTH+1:0] carries;
   logic [MASK_DEPTH:0]   closed_vec;
   logic [MASK_DEPTH-1:0] tok_star_vec;
   logic [MASK_DEPTH-1:0] tok_miss_vec;
   logic                  any_star;
   logic                  any_miss;
   rsp_item_type          result;
   logic                  buf_full;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;
   assign char_code  = CHAR_BITS'(req_item.char_value);

   assign ctrl.load      = req_accept && (req_item.opcode == OP_LOAD_MASK);
   assign ctrl.name_step = req_accept && (req_item.opcode == OP_NAME_CHAR);
   assign ctrl.tok_step  = ctrl.name_step && !decided_ff;
   assign ctrl.rearm     = req_accept && (req_item.opcode == OP_END_NAME);

   for (genvar i = 0; i < MASK_DEPTH; i++) begin : g_cells
      logic prev_fwd;
      logic prev_tok_pass;
      if (i == 0) begin : g_first
         assign prev_fwd      = 1'b0;
         assign prev_tok_pass = 1'b0;
      end else begin : g_rest
         assign prev_fwd      = status[i-1].fwd;
         assign prev_tok_pass = status[i-1].tok_pass;
      end

      wnm_cell #(
         .CHAR_BITS (CHAR_BITS),
         .LEN_W     (LEN_W),
         .POSITION  (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .load_index    (req_item.mask_index),
         .char_code     (char_code),
         .mask_len      (mask_len_ff),
         .closed        (closed_vec[i]),
         .prev_fwd      (prev_fwd),
         .prev_tok_pass (prev_tok_pass),
         .status        (status[i])
      );

      assign gen_vec[i]      = status[i].act;
      assign prop_vec[i+1]   = status[i].star_prop;
      assign tok_star_vec[i] = status[i].tok_star;
      assign tok_miss_vec[i] = status[i].tok_miss;
   end

   assign gen_vec[MASK_DEPTH] = act_end_ff;
   assign prop_vec[0]         = 1'b0;

   // Star closure as a carry chain: generate = active, propagate = star to the left.
   assign add_a      = {1'b0, gen_vec | prop_vec};
   assign add_b      = {1'b0, gen_vec};
   assign carries    = (add_a + add_b) ^ add_a ^ add_b;
   assign closed_vec = carries[MASK_DEPTH+1:1];

   assign any_star = |tok_star_vec;
   assign any_miss = (|tok_miss_vec) || tok_end_ff;  // token past the last cell is beyond the mask

   assign result.full_match       = closed_vec[mask_len_ff];
   assign result.prefix_may_match = !decided_ff || verdict_ff;

   always_comb begin
      mask_len_in = mask_len_ff;
      if (csr_wr_en) begin
         mask_len_in = (csr_wr_data > LEN_BITS'(MASK_DEPTH)) ? LEN_W'(MASK_DEPTH)
                                                             : LEN_W'(csr_wr_data);
      end

      priority if (ctrl.name_step) begin
         act_end_in = status[MASK_DEPTH-1].fwd;
      end else if (ctrl.rearm) begin
         act_end_in = 1'b0;
      end else begin
         act_end_in = act_end_ff;
      end

      priority if (ctrl.tok_step) begin
         tok_end_in = status[MASK_DEPTH-1].tok_pass;
      end else if (ctrl.rearm) begin
         tok_end_in = 1'b0;
      end else begin
         tok_end_in = tok_end_ff;
      end

      decided_in = decided_ff;
      verdict_in = verdict_ff;
      priority if (ctrl.rearm) begin
         decided_in = 1'b0;
         verdict_in = 1'b0;
      end else if (ctrl.tok_step && any_star) begin
         decided_in = 1'b1;
         verdict_in = 1'b1;
      end else if (ctrl.tok_step && any_miss) begin
         decided_in = 1'b1;
         verdict_in = 1'b0;
      end else begin
         decided_in = decided_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_len_ff <= '0;
         act_end_ff  <= 1'b0;
         tok_end_ff  <= 1'b0;
         decided_ff  <= 1'b0;
         verdict_ff  <= 1'b0;
      end else begin
         mask_len_ff <= mask_len_in;
         act_end_ff  <= act_end_in;
         tok_end_ff  <= tok_end_in;
         decided_ff  <= decided_in;
         verdict_ff  <= verdict_in;
      end
   end

   wnm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (ctrl.rearm),
      .push_item (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
